// File: rtl/asipe_pkg.sv
package asipe_pkg;

    localparam int SMP_W      = 16;
    localparam int GAIN_W     = 12;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int REM_W      = 11;
    localparam int PROD_W     = SMP_W + GAIN_W + 1;
    localparam int FRAC_W     = 8;
    localparam int SCL_W      = PROD_W - FRAC_W;
    localparam int SUM_W      = SCL_W + 1;
    localparam int TAB_IDX_W  = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_I2S      = 2'd0,
        MODE_I2S_SWAP = 2'd1,
        MODE_PWM5     = 2'd2,
        MODE_PWM7     = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = CFG_IDX_W'(1);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(742);

    typedef struct packed {
        t_mode            mode;
        logic [SMP_W-1:0] data;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [WORD_W-1:0] pdm_word(input logic [TAB_IDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        case (idx)
            6'd0:    w = 32'h00000000;
            6'd1:    w = 32'h00000001;
            6'd2:    w = 32'h00010001;
            6'd3:    w = 32'h01010001;
            6'd4:    w = 32'h01010101;
            6'd5:    w = 32'h01110101;
            6'd6:    w = 32'h01110111;
            6'd7:    w = 32'h01111111;
            6'd8:    w = 32'h11111111;
            6'd9:    w = 32'h11111113;
            6'd10:   w = 32'h11131113;
            6'd11:   w = 32'h13131113;
            6'd12:   w = 32'h13131313;
            6'd13:   w = 32'h13331313;
            6'd14:   w = 32'h13331333;
            6'd15:   w = 32'h13333333;
            6'd16:   w = 32'h33333333;
            6'd17:   w = 32'h33333337;
            6'd18:   w = 32'h33373337;
            6'd19:   w = 32'h37373337;
            6'd20:   w = 32'h37373737;
            6'd21:   w = 32'h37773737;
            6'd22:   w = 32'h37773777;
            6'd23:   w = 32'h37777777;
            6'd24:   w = 32'h77777777;
            6'd25:   w = 32'h7777777f;
            6'd26:   w = 32'h777f777f;
            6'd27:   w = 32'h7f7f777f;
            6'd28:   w = 32'h7f7f7f7f;
            6'd29:   w = 32'h7fff7f7f;
            6'd30:   w = 32'h7fff7fff;
            6'd31:   w = 32'h7fffffff;
            default: w = 32'hffffffff;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/asipe_if.sv
interface asipe_smp_if;
    logic                               valid;
    logic                               ready;
    logic signed [asipe_pkg::SMP_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface asipe_word_if;
    logic                         valid;
    logic                         ready;
    logic [asipe_pkg::WORD_W-1:0] word;
    logic                         last;

    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

interface asipe_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [asipe_pkg::CFG_IDX_W-1:0]  index;
    logic [asipe_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/asipe_front.sv
module asipe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    asipe_smp_if.sink            i_smp,
    asipe_cfg_if.sink            i_cfg,
    output asipe_pkg::t_job      o_job,
    output logic                 o_push,
    input  asipe_pkg::t_fifo_stat i_stat
);

    asipe_pkg::t_mode                          r_mode;
    logic [asipe_pkg::GAIN_W-1:0]              r_gain;
    logic                                      r_p_valid;
    logic signed [asipe_pkg::PROD_W-1:0]       r_prod;
    logic [asipe_pkg::REM_W-1:0]               r_rem;

    logic signed [asipe_pkg::PROD_W-1:0]       n_prod;
    logic [asipe_pkg::REM_W-1:0]               n_rem;
    logic signed [asipe_pkg::PROD_W-1:0]       biased;
    logic [asipe_pkg::SCL_W-1:0]               scaled;
    logic [asipe_pkg::SUM_W-1:0]               sum;
    logic [asipe_pkg::SMP_W-1:0]               s_clamp;
    logic [asipe_pkg::SMP_W-1:0]               v;
    logic                                      is_pwm;
    logic                                      in_beat;

    assign i_cfg.ready = 1'b1;
    assign o_push      = r_p_valid && !i_stat.full;
    assign i_smp.ready = !r_p_valid || o_push;
    assign in_beat     = i_smp.valid && i_smp.ready;
    assign is_pwm      = (r_mode == asipe_pkg::MODE_PWM5) || (r_mode == asipe_pkg::MODE_PWM7);

    assign n_prod = i_smp.sample * $signed({1'b0, r_gain});

    // truncate toward zero on the divide by 256
    assign biased = r_prod + (r_prod[asipe_pkg::PROD_W-1]
                    ? asipe_pkg::PROD_W'((1 << asipe_pkg::FRAC_W) - 1)
                    : asipe_pkg::PROD_W'(0));
    assign scaled = biased[asipe_pkg::PROD_W-1:asipe_pkg::FRAC_W];
    assign v      = scaled[asipe_pkg::SMP_W-1:0];

    // offset to unsigned, subtract remainder
    assign sum = {scaled[asipe_pkg::SCL_W-1], scaled}
               + asipe_pkg::SUM_W'(32768)
               - asipe_pkg::SUM_W'(r_rem);

    always_comb begin
        if (sum[asipe_pkg::SUM_W-1]) begin
            s_clamp = '0;
        end else if (|sum[asipe_pkg::SUM_W-2:asipe_pkg::SMP_W]) begin
            s_clamp = '1;
        end else begin
            s_clamp = sum[asipe_pkg::SMP_W-1:0];
        end
    end

    always_comb begin
        o_job.mode = r_mode;
        n_rem      = r_rem;
        case (r_mode)
            asipe_pkg::MODE_I2S: begin
                o_job.data = v;
            end
            asipe_pkg::MODE_I2S_SWAP: begin
                o_job.data = {v[7:0], v[15:8]};
            end
            asipe_pkg::MODE_PWM5: begin
                o_job.data = s_clamp;
                n_rem      = s_clamp[10:0];
            end
            asipe_pkg::MODE_PWM7: begin
                o_job.data = s_clamp;
                n_rem      = {2'b00, s_clamp[8:0]};
            end
            default: begin
                o_job.data = v;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= asipe_pkg::MODE_I2S;
            r_gain    <= asipe_pkg::GAIN_RESET;
            r_p_valid <= 1'b0;
            r_rem     <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    asipe_pkg::CFG_MODE: r_mode <= asipe_pkg::t_mode'(i_cfg.data[1:0]);
                    asipe_pkg::CFG_GAIN: r_gain <= i_cfg.data[asipe_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (in_beat) begin
                r_p_valid <= 1'b1;
            end else if (o_push) begin
                r_p_valid <= 1'b0;
            end
            if (o_push && is_pwm) begin
                r_rem <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_prod <= n_prod;
        end
    end

    a_rem_only_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_push && is_pwm) |=> $stable(r_rem))
        else $error("remainder changed without a pwm job");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid && i_stat.full |=> r_p_valid && $stable(r_prod))
        else $error("product lost while queue full");

endmodule

// File: rtl/asipe_fifo.sv
module asipe_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  asipe_pkg::t_job       i_job,
    input  logic                  i_pop,
    output asipe_pkg::t_job       o_job,
    output asipe_pkg::t_fifo_stat o_stat
);

    asipe_pkg::t_job                   r_mem [asipe_pkg::FIFO_DEPTH];
    logic [asipe_pkg::FIFO_PTR_W-1:0]  r_wr;
    logic [asipe_pkg::FIFO_PTR_W-1:0]  r_rd;
    logic [asipe_pkg::FIFO_CNT_W-1:0]  r_count;

    assign o_stat.full  = (r_count == asipe_pkg::FIFO_CNT_W'(asipe_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= asipe_pkg::FIFO_CNT_W'(asipe_pkg::FIFO_DEPTH))
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

// File: rtl/asipe_back.sv
module asipe_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  asipe_pkg::t_job       i_job,
    input  asipe_pkg::t_fifo_stat i_stat,
    output logic                  o_pop,
    asipe_word_if.source          o_word
);

    logic                                r_valid;
    logic [1:0]                          r_beat;
    logic [asipe_pkg::WORD_W-1:0]        r_word;
    logic                                r_last;

    logic                                load;
    logic                                last_beat;
    logic [7:0]                          idx_sum;
    logic [asipe_pkg::TAB_IDX_W-1:0]     idx7;
    logic [asipe_pkg::WORD_W-1:0]        n_word;

    assign load      = !i_stat.empty && (!r_valid || o_word.ready);
    assign last_beat = (i_job.mode != asipe_pkg::MODE_PWM7) || (r_beat == 2'd3);
    assign o_pop     = load && last_beat;

    // seven-bit mode: beat i picks entry (t + 3 - i) >> 2
    assign idx_sum = {1'b0, i_job.data[15:9]} + {6'b0, 2'd3 - r_beat};
    assign idx7    = idx_sum[7:2];

    always_comb begin
        case (i_job.mode)
            asipe_pkg::MODE_I2S:      n_word = {i_job.data, i_job.data};
            asipe_pkg::MODE_I2S_SWAP: n_word = {i_job.data, i_job.data};
            asipe_pkg::MODE_PWM5:     n_word = asipe_pkg::pdm_word({1'b0, i_job.data[15:11]});
            asipe_pkg::MODE_PWM7:     n_word = asipe_pkg::pdm_word(idx7);
            default:                  n_word = {i_job.data, i_job.data};
        endcase
    end

    assign o_word.valid = r_valid;
    assign o_word.word  = r_word;
    assign o_word.last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_beat  <= last_beat ? 2'd0 : r_beat + 2'd1;
            end else if (o_word.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
            r_last <= last_beat;
        end
    end

    a_beat_in_pwm7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat != 2'd0 |-> !i_stat.empty && i_job.mode == asipe_pkg::MODE_PWM7)
        else $error("beat count outside a seven-bit job");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && !last_beat |=> !i_stat.empty && $stable(i_job))
        else $error("queue head moved mid job");

endmodule

// File: rtl/audio_sample_i2s_pwm_encoder_core.sv
// Audio sample encoder for a 32-bit I2S serializer. Each sample beat is scaled by the
// unsigned Q4.8 gain and turned into one output word (I2S, I2S byte-swapped, five-bit
// PWM) or four words with last on the fourth (seven-bit PWM); PWM modes carry an
// error-feedback remainder across samples and mode changes. Samples are taken every
// cycle while the queue has room, into a multiply stage and a shaping stage that
// feed a four-entry job queue; the output side issues one word per cycle from a single
// output register while the queue holds a job and the receiver is ready, so it takes
// one word per sample in the one-word modes and four words per seven-bit PWM sample.
// A sample's first word reaches the output through the product register, the job
// queue and the output word register. Configuration writes are always taken (ready
// held high) and should be made only while idle.
module audio_sample_i2s_pwm_encoder_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    asipe_smp_if.sink     i_smp,
    asipe_cfg_if.sink     i_cfg,
    asipe_word_if.source  o_word
);

    asipe_pkg::t_job       push_job;
    asipe_pkg::t_job       head_job;
    asipe_pkg::t_fifo_stat stat;
    logic                  push;
    logic                  pop;

    asipe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_smp),
        .i_cfg   (i_cfg),
        .o_job   (push_job),
        .o_push  (push),
        .i_stat  (stat)
    );

    asipe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (stat)
    );

    asipe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_word  (o_word)
    );

endmodule

// File: sim/tb_top.sv
module tb_top;

    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 500;
    localparam logic [31:0] NIBBLE_RANK = 32'h7241_6350;

    typedef struct packed {
        logic [asipe_pkg::WORD_W-1:0] word;
        logic                         last;
    } t_word_exp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    asipe_smp_if  smp_if();
    asipe_cfg_if  cfg_if();
    asipe_word_if word_if();

    audio_sample_i2s_pwm_encoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .i_cfg   (cfg_if),
        .o_word  (word_if)
    );

    t_word_exp                     pending_words[$];
    asipe_pkg::t_mode              cur_mode = asipe_pkg::MODE_I2S;
    logic [asipe_pkg::GAIN_W-1:0]  cur_gain = asipe_pkg::GAIN_RESET;
    logic [asipe_pkg::REM_W-1:0]   pwm_residue = '0;
    int                            mismatches = 0;
    int                            burst_left = 0;
    int                            rx_style = 0;
    int                            rx_left = 0;
    int                            rx_phase = 0;

    always #4 i_clk = ~i_clk;

    // pulse-density word with k of 32 bits set, spread over the nibbles
    function automatic logic [asipe_pkg::WORD_W-1:0] density_word(input int k);
        logic [asipe_pkg::WORD_W-1:0] w;
        int lvl;
        w = '0;
        for (int n = 0; n < 8; n++) begin
            lvl = k / 8 + ((int'(NIBBLE_RANK[4*n +: 4]) < k % 8) ? 1 : 0);
            w[4*n +: 4] = 4'((1 << lvl) - 1);
        end
        return w;
    endfunction

    function automatic void encode_sample(input logic [asipe_pkg::SMP_W-1:0] smp);
        longint      scaled;
        longint      level;
        logic [15:0] v;
        logic [15:0] lvl16;
        int          top;
        scaled = (longint'($signed(smp)) * longint'(cur_gain)) / 256;
        if (cur_mode == asipe_pkg::MODE_I2S || cur_mode == asipe_pkg::MODE_I2S_SWAP) begin
            v = scaled[15:0];
            if (cur_mode == asipe_pkg::MODE_I2S_SWAP) begin
                v = {v[7:0], v[15:8]};
            end
            pending_words.push_back(t_word_exp'{word: {v, v}, last: 1'b1});
        end else begin
            level = scaled + 32768 - longint'(pwm_residue);
            if (level < 0) begin
                level = 0;
            end else if (level > 65535) begin
                level = 65535;
            end
            lvl16 = level[15:0];
            if (cur_mode == asipe_pkg::MODE_PWM5) begin
                pwm_residue = lvl16[10:0];
                pending_words.push_back(t_word_exp'{
                    word: density_word(int'(lvl16[15:11])), last: 1'b1});
            end else begin
                pwm_residue = {2'b00, lvl16[8:0]};
                top = int'(lvl16[15:9]);
                for (int i = 0; i < 4; i++) begin
                    pending_words.push_back(t_word_exp'{
                        word: density_word((top + 3 - i) >> 2), last: (i == 3)});
                end
            end
        end
    endfunction

    task automatic send_sample(input logic [asipe_pkg::SMP_W-1:0] smp);
        if (burst_left == 0) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= smp;
        do @(posedge i_clk); while (!smp_if.ready);
        encode_sample(smp);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic drain_words();
        smp_if.valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending_words.size() != 0);
    endtask

    task automatic cfg_write(input logic [asipe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [asipe_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            asipe_pkg::CFG_MODE: cur_mode = asipe_pkg::t_mode'(data[1:0]);
            asipe_pkg::CFG_GAIN: cur_gain = data[asipe_pkg::GAIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input asipe_pkg::t_mode m,
                              input logic [asipe_pkg::GAIN_W-1:0] g);
        drain_words();
        cfg_write(asipe_pkg::CFG_MODE, {14'($urandom), m});
        cfg_write(asipe_pkg::CFG_GAIN, {4'($urandom), g});
    endtask

    function automatic logic [asipe_pkg::SMP_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            5, 6:    return 16'(int'($urandom_range(0, 600)) - 300);
            7:       return 16'h7fff - 16'($urandom_range(0, 3));
            8:       return 16'h8000 + 16'($urandom_range(0, 3));
            9:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [asipe_pkg::GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 12'd4095;
            2:       return 12'd256;
            3:       return asipe_pkg::GAIN_RESET;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(16'h7fff);
        send_sample(16'h8000);
    endtask

    task automatic test_i2s_plain();
        set_config(asipe_pkg::MODE_I2S, 12'd256);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hffff);
        send_sample(16'h1234);
    endtask

    task automatic test_i2s_byte_swap();
        set_config(asipe_pkg::MODE_I2S_SWAP, 12'd384);
        send_sample(16'h1234);
        send_sample(16'h8001);
    endtask

    task automatic test_large_gain();
        set_config(asipe_pkg::MODE_I2S, 12'd4095);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        set_config(asipe_pkg::MODE_PWM5, 12'd4095);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        set_config(asipe_pkg::MODE_PWM7, 12'd0);
        send_sample(16'h5555);
    endtask

    task automatic test_pwm5();
        set_config(asipe_pkg::MODE_PWM5, 12'd256);
        send_sample(16'h0000);
        send_sample(16'h0400);
        send_sample(16'hfc00);
        send_sample(16'h7fff);
    endtask

    task automatic test_pwm7();
        set_config(asipe_pkg::MODE_PWM7, 12'd256);
        send_sample(16'h0000);
        send_sample(16'h0123);
        send_sample(16'h8000);
        send_sample(16'h7fff);
    endtask

    // residue survives trips through the i2s modes
    task automatic test_mode_change();
        set_config(asipe_pkg::MODE_PWM5, 12'd200);
        send_sample(16'h0abc);
        set_config(asipe_pkg::MODE_I2S, 12'd200);
        send_sample(16'h0101);
        set_config(asipe_pkg::MODE_PWM7, 12'd200);
        send_sample(16'h0abc);
    endtask

    task automatic test_ignored_writes();
        drain_words();
        cfg_write(8'd2, 16'h0001);
        cfg_write(8'hff, 16'hffff);
        cfg_write(8'h80, 16'h0002);
        cfg_write(asipe_pkg::CFG_MODE, 16'hfffd);
        cfg_write(asipe_pkg::CFG_GAIN, 16'hf0ff);
        send_sample(16'h4321);
        send_sample(16'hbcde);
    endtask

    task automatic test_random_stream();
        int sent;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_config(asipe_pkg::t_mode'($urandom_range(0, 3)), random_gain());
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(8'($urandom_range(2, 255)), 16'($urandom));
            end
            n = $urandom_range(10, 60);
            repeat (n) send_sample(random_sample());
            sent += n;
        end
    endtask

    // receiver: always ready, random, periodic, or long stalls
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(64, 300);
            rx_phase = 0;
        end
        rx_left--;
        rx_phase++;
        case (rx_style)
            0:       word_if.ready <= 1'b1;
            1:       word_if.ready <= 1'($urandom_range(0, 1));
            2:       word_if.ready <= (rx_phase % 7) < 4;
            default: word_if.ready <= (rx_phase % 24) >= 16;
        endcase
    end

    always @(posedge i_clk) begin : word_check
        t_word_exp exp_w;
        if (i_rst_n && word_if.valid && word_if.ready) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat expected none actual word %08h last %0b",
                         $time, word_if.word, word_if.last);
            end else begin
                exp_w = pending_words.pop_front();
                if (exp_w.word !== word_if.word) begin
                    mismatches++;
                    $display("%0t: word mismatch expected %08h actual %08h",
                             $time, exp_w.word, word_if.word);
                end
                if (exp_w.last !== word_if.last) begin
                    mismatches++;
                    $display("%0t: last mismatch expected %0b actual %0b",
                             $time, exp_w.last, word_if.last);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((smp_if.valid && smp_if.ready) || (word_if.valid && word_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        smp_if.valid   = 1'b0;
        smp_if.sample  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        word_if.ready  = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_i2s_plain();
        test_i2s_byte_swap();
        test_large_gain();
        test_pwm5();
        test_pwm7();
        test_mode_change();
        test_ignored_writes();
        test_random_stream();

        drain_words();
        repeat (16) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/asipe_pkg.sv
rtl/asipe_if.sv
rtl/asipe_front.sv
rtl/asipe_fifo.sv
rtl/asipe_back.sv
rtl/audio_sample_i2s_pwm_encoder_core.sv
sim/tb_top.sv
